>>> hdl/pev_pkg.sv
// ----------------------------------------------------------------------------
// pev_pkg
// Shared types and fixed constants of the polygon edge resampler.
// ----------------------------------------------------------------------------
package pev_pkg;

	localparam int CFG_W     = 24;
	localparam int MUL_DIGIT = 8;
	localparam logic [CFG_W-1:0] MAX_LEN_RESET = 24'd256;

	localparam logic ACT_SEED   = 1'b0;
	localparam logic ACT_VERTEX = 1'b1;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_CMP,
		F_SRCH,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		OP_DX,
		OP_DY,
		OP_MAX
	} mul_op_t;

endpackage

>>> hdl/pev_fifo.sv
// ----------------------------------------------------------------------------
// pev_fifo
// Small register queue between the edge classifier and the point generator.
// ----------------------------------------------------------------------------
module pev_fifo
	import pev_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

>>> hdl/pev_front.sv
// ----------------------------------------------------------------------------
// pev_front
// Accepts words, tracks the previous point, squares the edge and counts the
// points to insert with an add-only search.
// ----------------------------------------------------------------------------
module pev_front
	import pev_pkg::*;
#(
	parameter int MAX_EXTRAS = 63,
	parameter int COORD_BITS = 24,
	parameter int IN_W       = 48,
	parameter int QW         = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tuser,
	input  logic [CFG_W-1:0] max_len,
	output logic             q_push,
	input  logic             q_full,
	output logic [QW-1:0]    q_data
);

	localparam int CW  = COORD_BITS;
	localparam int DW  = CW + 1;
	localparam int MW  = (DW > CFG_W) ? DW : CFG_W;
	localparam int PW  = 2 * MW;
	localparam int NB  = (MW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int NBW = $clog2(NB + 1);
	localparam int KW  = $clog2(MAX_EXTRAS + 2);
	localparam int EW  = $clog2(MAX_EXTRAS + 1);
	localparam int SW  = PW + 2 * KW + 2;

	front_state_t st_q, st_d;
	mul_op_t      mi_q;

	logic signed [CW-1:0] vx, vy;
	logic signed [CW-1:0] prev_x_q, prev_y_q, ex_px_q, ex_py_q, vx_q, vy_q;
	logic signed [DW-1:0] dx_in, dy_in, dx_q, dy_q;
	logic [DW-1:0]        ady;
	logic [PW-1:0]        mc_q, prod, op_next;
	logic [MW-1:0]        mp_q;
	logic [NBW-1:0]       mcnt_q;
	logic [PW:0]          lensq_q;
	logic [PW-1:0]        maxsq_q;
	logic [SW-1:0]        t_q, s_q, ts;
	logic [KW-1:0]        k_q;
	logic [EW-1:0]        extras;
	logic                 clip, accept, mul_last, srch_go;

	assign vx = s_tdata[CW-1:0];
	assign vy = s_tdata[2*CW-1:CW];
	assign dx_in = DW'(vx) - DW'(prev_x_q);
	assign dy_in = DW'(vy) - DW'(prev_y_q);
	assign ady = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);

	assign accept   = s_tvalid && s_tready;
	assign prod     = PW'(mc_q * mp_q[MUL_DIGIT-1:0]);
	assign mul_last = (mcnt_q == NBW'(NB - 1));
	assign ts       = t_q + s_q;
	assign srch_go  = (k_q <= KW'(MAX_EXTRAS)) && (ts <= SW'(lensq_q));
	assign clip     = (k_q > KW'(MAX_EXTRAS));
	assign extras   = clip ? EW'(MAX_EXTRAS) : EW'(k_q);

	always_comb begin
		case (mi_q)
			OP_DX:   op_next = PW'(ady);
			default: op_next = PW'(max_len);
		endcase
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			F_IDLE: begin
				if (accept && s_tuser == ACT_VERTEX) st_d = F_MUL;
			end
			F_MUL: begin
				if (mul_last && mi_q == OP_MAX) st_d = F_CMP;
			end
			F_CMP: begin
				st_d = ((PW+1)'(maxsq_q) < lensq_q) ? F_SRCH : F_PUSH;
			end
			F_SRCH: begin
				if (!srch_go) st_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) st_d = F_IDLE;
			end
			default: st_d = F_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (st_q == F_IDLE);
		q_push   = (st_q == F_PUSH);
		q_data   = {clip, extras, dy_q, dx_q, vy_q, vx_q, ex_py_q, ex_px_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= F_IDLE;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			st_q <= st_d;
			if (accept) begin
				prev_x_q <= vx;
				prev_y_q <= vy;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				ex_px_q <= prev_x_q;
				ex_py_q <= prev_y_q;
				vx_q    <= vx;
				vy_q    <= vy;
				dx_q    <= dx_in;
				dy_q    <= dy_in;
				mi_q    <= OP_DX;
				mcnt_q  <= '0;
				lensq_q <= '0;
				maxsq_q <= '0;
				mc_q    <= PW'(dx_in[DW-1] ? DW'(-dx_in) : DW'(dx_in));
				mp_q    <= MW'(dx_in[DW-1] ? DW'(-dx_in) : DW'(dx_in));
			end
			F_MUL: begin
				// one byte of the multiplier per cycle
				if (mi_q == OP_MAX) maxsq_q <= maxsq_q + prod;
				else                lensq_q <= lensq_q + (PW+1)'(prod);
				if (mul_last) begin
					mcnt_q <= '0;
					mc_q   <= op_next;
					mp_q   <= MW'(op_next);
					mi_q   <= (mi_q == OP_DX) ? OP_DY : OP_MAX;
				end else begin
					mcnt_q <= mcnt_q + 1'b1;
					mc_q   <= mc_q << MUL_DIGIT;
					mp_q   <= mp_q >> MUL_DIGIT;
				end
			end
			F_CMP: begin
				k_q <= '0;
				t_q <= '0;
				s_q <= SW'(maxsq_q);
			end
			F_SRCH: begin
				// (k+1)^2 - k^2 = 2k+1: advance the step by twice maxsq
				if (srch_go) begin
					t_q <= ts;
					s_q <= s_q + (SW'(maxsq_q) << 1);
					k_q <= k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/pev_back.sv
// ----------------------------------------------------------------------------
// pev_back
// Divides the edge by the piece count once when points are inserted, then steps
// through the inserted points and the vertex, one output word per cycle while m_tready allows.
// ----------------------------------------------------------------------------
module pev_back
	import pev_pkg::*;
#(
	parameter int MAX_EXTRAS = 63,
	parameter int COORD_BITS = 24,
	parameter int OUT_W      = 48,
	parameter int QW         = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  logic [QW-1:0]    q_data,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	localparam int CW   = COORD_BITS;
	localparam int DW   = CW + 1;
	localparam int EW   = $clog2(MAX_EXTRAS + 1);
	localparam int DENW = EW + 1;
	localparam int RW   = DENW + 1;
	localparam int CNW  = $clog2(DW + 1);

	back_state_t st_q, st_d;

	logic signed [CW-1:0] q_px, q_py, q_vx, q_vy, px_q, py_q, vx_q, vy_q;
	logic signed [DW-1:0] q_dx, q_dy;
	logic [EW-1:0]        q_ext, ext_q, j_q;
	logic                 q_clip, clip_q, negx_q, negy_q;

	logic [DW-1:0]   nx_q, ny_q, qx_q, qy_q, accx_q, accy_q, accx_n, accy_n;
	logic [RW-1:0]   rx_q, ry_q, rtx, rty, remx_q, remy_q, rsx, rsy;
	logic [DENW-1:0] den_q;
	logic [CNW-1:0]  cnt_q;
	logic            gex, gey, slot, last_pt;
	logic [DW-1:0]   sx, sy;

	logic [CW-1:0] o_px_q, o_py_q;
	logic          o_orig_q, o_last_q, o_clip_q, o_valid_q;

	assign {q_clip, q_ext, q_dy, q_dx, q_vy, q_vx, q_py, q_px} = q_data;

	// restoring division, one quotient bit per cycle for both axes
	assign rtx = {rx_q[RW-2:0], nx_q[DW-1]};
	assign rty = {ry_q[RW-2:0], ny_q[DW-1]};
	assign gex = (rtx >= RW'(den_q));
	assign gey = (rty >= RW'(den_q));

	// running num*|d|/den: add quotient and remainder, fold one carry
	assign rsx    = remx_q + rx_q;
	assign rsy    = remy_q + ry_q;
	assign accx_n = accx_q + qx_q + DW'(rsx >= RW'(den_q));
	assign accy_n = accy_q + qy_q + DW'(rsy >= RW'(den_q));

	assign sx = negx_q ? DW'(-accx_q) : accx_q;
	assign sy = negy_q ? DW'(-accy_q) : accy_q;

	assign slot    = !o_valid_q || m_tready;
	assign last_pt = (j_q == ext_q);

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: begin
				if (q_valid) st_d = (q_ext == '0) ? B_EMIT : B_DIV;
			end
			B_DIV: begin
				if (cnt_q == CNW'(DW - 1)) st_d = B_EMIT;
			end
			B_EMIT: begin
				if (slot && last_pt) st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (st_q == B_IDLE);
		m_tvalid = o_valid_q;
		m_tdata  = OUT_W'({o_py_q, o_px_q});
		m_tuser  = {o_clip_q, o_orig_q};
		m_tlast  = o_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			o_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == B_EMIT && slot) o_valid_q <= 1'b1;
			else if (m_tready)          o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				px_q   <= q_px;
				py_q   <= q_py;
				vx_q   <= q_vx;
				vy_q   <= q_vy;
				negx_q <= q_dx[DW-1];
				negy_q <= q_dy[DW-1];
				nx_q   <= q_dx[DW-1] ? DW'(-q_dx) : DW'(q_dx);
				ny_q   <= q_dy[DW-1] ? DW'(-q_dy) : DW'(q_dy);
				ext_q  <= q_ext;
				clip_q <= q_clip;
				den_q  <= DENW'(q_ext) + 1'b1;
				rx_q   <= '0;
				ry_q   <= '0;
				qx_q   <= '0;
				qy_q   <= '0;
				cnt_q  <= '0;
				j_q    <= '0;
			end
			B_DIV: begin
				rx_q  <= gex ? rtx - RW'(den_q) : rtx;
				ry_q  <= gey ? rty - RW'(den_q) : rty;
				qx_q  <= {qx_q[DW-2:0], gex};
				qy_q  <= {qy_q[DW-2:0], gey};
				nx_q  <= nx_q << 1;
				ny_q  <= ny_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(DW - 1)) begin
					accx_q <= {qx_q[DW-2:0], gex};
					accy_q <= {qy_q[DW-2:0], gey};
					remx_q <= gex ? rtx - RW'(den_q) : rtx;
					remy_q <= gey ? rty - RW'(den_q) : rty;
				end
			end
			B_EMIT: begin
				if (slot) begin
					o_clip_q <= clip_q;
					o_orig_q <= last_pt;
					o_last_q <= last_pt;
					if (last_pt) begin
						o_px_q <= vx_q;
						o_py_q <= vy_q;
					end else begin
						o_px_q <= CW'(DW'(px_q) + sx);
						o_py_q <= CW'(DW'(py_q) + sy);
						accx_q <= accx_n;
						accy_q <= accy_n;
						remx_q <= (rsx >= RW'(den_q)) ? rsx - RW'(den_q) : rsx;
						remy_q <= (rsy >= RW'(den_q)) ? rsy - RW'(den_q) : rsy;
						j_q    <= j_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/polygon_edge_resampler_top.sv
// ----------------------------------------------------------------------------
// polygon_edge_resampler_top
// Splits each polygon edge longer than max_edge_length into equal pieces.
// ----------------------------------------------------------------------------
// Input words on s_*: s_tuser 0 seeds the previous point, 1 is a vertex.
// For every vertex the block sends the inserted points, then the vertex
// itself with m_tlast high; m_tuser flags the vertex and a saturated count.
// The user must write max_edge_length on cfg_valid/cfg_data only while the
// block is idle; the block itself does not enforce it. The front takes one
// word, then squares dx, dy and max_edge_length in a byte-serial squarer,
// compares, and for a long edge runs the add-only search (one step per
// inserted point) before queueing the edge. A seed only updates the previous
// point. The back pops the queue, divides the edge by the piece count
// bit-serially when points are inserted, then sends one word per cycle while
// m_tready is high. Front and back overlap through a two-entry queue.
// Reset clears the previous point to zero, max_edge_length to 256 and drops
// queued work. A stalled m_tready holds the output word and backs up into
// the queue and then s_tready.
// ----------------------------------------------------------------------------
module polygon_edge_resampler_top
	import pev_pkg::*;
#(
	parameter int MAX_EXTRAS = 63,
	parameter int COORD_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [CFG_W-1:0]                     cfg_data,   // max_edge_length
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,    // vx, vy
	input  logic                                 s_tuser,    // action
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,    // px, py
	output logic [1:0]                           m_tuser,    // is_original, clipped
	output logic                                 m_tlast
);

	localparam int CW   = COORD_BITS;
	localparam int DW   = CW + 1;
	localparam int EW   = $clog2(MAX_EXTRAS + 1);
	localparam int IO_W = ((2*CW + 7) / 8) * 8;
	localparam int QW   = 4*CW + 2*DW + EW + 1;

	logic [CFG_W-1:0] max_len_q;
	logic             push, full, pop, not_empty;
	logic [QW-1:0]    wdata, rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	pev_front #(
		.MAX_EXTRAS (MAX_EXTRAS),
		.COORD_BITS (COORD_BITS),
		.IN_W       (IO_W),
		.QW         (QW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.max_len  (max_len_q),
		.q_push   (push),
		.q_full   (full),
		.q_data   (wdata)
	);

	pev_fifo #(
		.WIDTH (QW),
		.DEPTH (2)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (wdata),
		.full      (full),
		.pop       (pop),
		.rdata     (rdata),
		.not_empty (not_empty)
	);

	pev_back #(
		.MAX_EXTRAS (MAX_EXTRAS),
		.COORD_BITS (COORD_BITS),
		.OUT_W      (IO_W),
		.QW         (QW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_pop    (pop),
		.q_data   (rdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> bench/pev_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pev_checker
// Watches the config, input and output channels of the edge resampler,
// predicts every output word from its own copy of the previous point and
// max_edge_length, and compares each output word field by field.
// ----------------------------------------------------------------------------
module pev_checker
	import pev_pkg::*;
#(
	parameter int MAX_EXTRAS = 63,
	parameter int COORD_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [47:0]            s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [47:0]            m_tdata,
	input  logic [1:0]             m_tuser,
	input  logic                   m_tlast,
	output int                     fail_count,
	output int                     pending,
	output int                     points_seen,
	output int                     clipped_seen
);

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  orig;
		logic                  last;
		logic                  clip;
	} point_t;

	point_t          point_q[$];
	logic [CFG_W-1:0] max_len;
	longint          prev_x, prev_y;

	function automatic longint sx(logic [COORD_BITS-1:0] v);
		return longint'(signed'(v));
	endfunction

	// split one edge into its inserted points and the vertex
	task automatic resample_edge(longint vx, longint vy);
		longint dx, dy, adx, ady, n, den;
		longint unsigned lensq, maxsq, k;
		logic clip;
		point_t p;
		dx = vx - prev_x;
		dy = vy - prev_y;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		lensq = adx * adx + ady * ady;
		maxsq = longint'(max_len) * longint'(max_len);
		k = 0;
		clip = 1'b0;
		if (lensq > maxsq) begin
			while (k < MAX_EXTRAS + 1 && (k + 1) * (k + 1) * maxsq <= lensq)
				k++;
			if (k > MAX_EXTRAS) begin
				k = MAX_EXTRAS;
				clip = 1'b1;
			end
		end
		den = k + 1;
		for (longint j = 0; j < k; j++) begin
			n = j + 1;
			// SV division truncates toward zero, same as the intent
			p.x = COORD_BITS'(prev_x + (n * dx) / den);
			p.y = COORD_BITS'(prev_y + (n * dy) / den);
			p.orig = 1'b0;
			p.last = 1'b0;
			p.clip = clip;
			point_q.push_back(p);
		end
		p.x = COORD_BITS'(vx);
		p.y = COORD_BITS'(vy);
		p.orig = 1'b1;
		p.last = 1'b1;
		p.clip = clip;
		point_q.push_back(p);
		prev_x = vx;
		prev_y = vy;
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_t e;
		longint vx, vy;
		if (!arst_n) begin
			point_q.delete();
			max_len = MAX_LEN_RESET;
			prev_x = 0;
			prev_y = 0;
			fail_count = 0;
			points_seen = 0;
			clipped_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_len = cfg_data;
			if (s_tvalid && s_tready) begin
				vx = sx(s_tdata[COORD_BITS-1:0]);
				vy = sx(s_tdata[2*COORD_BITS-1:COORD_BITS]);
				if (s_tuser == ACT_SEED) begin
					prev_x = vx;
					prev_y = vy;
				end else begin
					resample_edge(vx, vy);
				end
			end
			if (m_tvalid && m_tready) begin
				points_seen++;
				if (point_q.size() == 0) begin
					$error("unexpected output word px=%h py=%h", m_tdata[23:0],
						m_tdata[47:24]);
					fail_count++;
				end else begin
					e = point_q.pop_front();
					if (e.clip) clipped_seen++;
					if (m_tdata[COORD_BITS-1:0] !== e.x) begin
						$error("px expected %h actual %h", e.x, m_tdata[COORD_BITS-1:0]);
						fail_count++;
					end
					if (m_tdata[2*COORD_BITS-1:COORD_BITS] !== e.y) begin
						$error("py expected %h actual %h", e.y,
							m_tdata[2*COORD_BITS-1:COORD_BITS]);
						fail_count++;
					end
					if (m_tuser[0] !== e.orig) begin
						$error("is_original expected %b actual %b", e.orig, m_tuser[0]);
						fail_count++;
					end
					if (m_tlast !== e.last) begin
						$error("last_of_run expected %b actual %b", e.last, m_tlast);
						fail_count++;
					end
					if (m_tuser[1] !== e.clip) begin
						$error("clipped expected %b actual %b", e.clip, m_tuser[1]);
						fail_count++;
					end
				end
			end
		end
		pending = point_q.size();
	end

endmodule

>>> bench/tb_polygon_edge_resampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_edge_resampler_top
// Drives vertex and seed words and max_edge_length settings into the edge
// resampler under random idling and back-pressure; the checker judges output.
// ----------------------------------------------------------------------------
module tb_polygon_edge_resampler_top;
	import pev_pkg::*;

	localparam int CB = 24;
	localparam int WATCHDOG = 20000;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [47:0]      s_tdata;    // vx, vy
	logic             s_tuser;    // action
	logic             m_tvalid;
	logic             m_tready;
	logic [47:0]      m_tdata;    // px, py
	logic [1:0]       m_tuser;    // is_original, clipped
	logic             m_tlast;

	int fail_count, pending, points_seen, clipped_seen;
	int idle_pct_s, idle_pct_m;
	bit hold_off;
	int quiet;
	int vertices_sent;

	polygon_edge_resampler_top dut (.*);

	pev_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= idle_pct_m);
		end
	end

	// count cycles with no handshake at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_word(logic act, logic signed [CB-1:0] x, logic signed [CB-1:0] y);
		while ($urandom_range(99) < idle_pct_s) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (act == ACT_VERTEX) vertices_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_max(logic [CFG_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [CB-1:0] rand_coord(int span);
		if (span >= 23) return CB'($urandom);
		return CB'($signed($urandom_range(2 * (1 << span))) - (1 << span));
	endfunction

	// one polygon: seed with its last vertex, then walk the vertices
	task automatic send_polygon(int span);
		logic signed [CB-1:0] xs[8], ys[8];
		int n;
		n = $urandom_range(3, 8);
		for (int i = 0; i < n; i++) begin
			xs[i] = rand_coord(span);
			ys[i] = rand_coord(span);
		end
		send_word(ACT_SEED, xs[n-1], ys[n-1]);
		for (int i = 0; i < n; i++) send_word(ACT_VERTEX, xs[i], ys[i]);
	endtask

	initial begin
		logic signed [CB-1:0] mx, mn;
		mx = 24'sh7fffff;
		mn = 24'sh800000;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_SEED;
		idle_pct_s = 34;
		idle_pct_m = 34;
		hold_off = 1'b0;
		quiet = 0;
		vertices_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no seed, short edge, long edges, extremes, zero length
		send_word(ACT_VERTEX, 24'sd100, 24'sd0);
		send_word(ACT_VERTEX, 24'sd1000, -24'sd1000);
		send_word(ACT_VERTEX, mx, mx);
		send_word(ACT_VERTEX, mn, mn);
		send_word(ACT_VERTEX, mn, mn);
		send_word(ACT_SEED, mx, mn);
		send_word(ACT_VERTEX, mn, mx);
		send_word(ACT_SEED, 24'sd0, 24'sd0);
		send_word(ACT_VERTEX, 24'sd256, 24'sd0);
		send_word(ACT_VERTEX, 24'sd256, 24'sd257);
		send_word(ACT_VERTEX, -24'sd3, 24'sd5000);
		write_max(24'd0);
		send_word(ACT_VERTEX, -24'sd3, 24'sd5000);
		send_word(ACT_VERTEX, -24'sd2, 24'sd5000);
		send_word(ACT_SEED, 24'sh555555, 24'shaaaaaa);
		send_word(ACT_VERTEX, 24'shaaaaaa, 24'sh555555);
		write_max(24'hffffff);
		send_word(ACT_VERTEX, mx, mx);
		send_word(ACT_VERTEX, mn, mn);
		write_max(24'd1);
		send_word(ACT_VERTEX, mn + 24'sd7, mn);
		send_word(ACT_VERTEX, mn + 24'sd7, mn + 24'sd63);

		// random polygons under several settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_max(24'd256);
				1: write_max(24'd40);
				2: write_max(24'(1 << $urandom_range(1, 22)));
				3: write_max(24'h7fffff);
				4: write_max(24'(1 + $urandom_range(5000)));
				default: write_max(24'd1000);
			endcase
			// a stretch with no idling on either side
			idle_pct_s = (ph == 3) ? 0 : 34;
			idle_pct_m = (ph == 3) ? 0 : 34;
			if (ph == 2) hold_off = 1'b1;
			for (int p = 0; p < 8; p++) begin
				if ($urandom_range(9) == 0)
					send_word(1'($urandom_range(1)), CB'($urandom), CB'($urandom));
				else
					send_polygon($urandom_range(4) == 0 ? 23 : $urandom_range(4, 14));
			end
			// pause until everything has drained
			if (ph == 4) drain();
		end

		drain();
		$display("Covered %0d vertices, %0d output points (%0d from clipped runs).",
			vertices_sent, points_seen, clipped_seen);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
